@@ rtl/arlp_pkg.sv @@
package arlp_pkg;

  localparam int MAX_DIGITS_DEFAULT = 9;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LT    = 8'h3C;

  localparam logic [7:0] OPEN_TAG [3] = '{8'h3C, 8'h73, 8'h3E};

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_SCORE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_SEARCH  = 3'd0,
    PH_COLLECT = 3'd1,
    PH_SKIP    = 3'd2,
    PH_BLANK   = 3'd3,
    PH_INT     = 3'd4,
    PH_FRAC    = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       is_zero;
    logic       is_num;
    logic       is_other;
    logic       is_lt;
    logic       is_tab;
    logic       is_blank;
    logic       is_minus;
    logic       is_plus;
    logic       is_dot;
  } char_class_t;

  function automatic logic [63:0] mant_limit(int digits);
    logic [63:0] v;
    v = 64'd1;
    for (int k = 0; k < digits; k++) begin
      v = v * 64'd10;
    end
    return v - 64'd1;
  endfunction

  function automatic int bits_for(logic [63:0] v);
    int n;
    n = 1;
    for (int k = 1; k < 64; k++) begin
      if (v >> k != 64'd0) begin
        n = k + 1;
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/arlp_in_if.sv @@
interface arlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

@@ rtl/arlp_out_if.sv @@
interface arlp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         item_kind;
  logic [7:0]         out_byte;
  logic signed [30:0] score_mantissa;
  logic [3:0]         frac_places;
  logic               last_of_run;

  modport source (output valid, output item_kind, output out_byte, output score_mantissa,
                  output frac_places, output last_of_run, input ready);
  modport sink (input valid, input item_kind, input out_byte, input score_mantissa,
                input frac_places, input last_of_run, output ready);
endinterface

@@ rtl/arlp_front.sv @@
module arlp_front
  import arlp_pkg::*;
(
  arlp_in_if.sink     chars,
  input  logic        full,
  output logic        push,
  output char_class_t entry
);

  logic [7:0] b;
  logic       num;
  logic       letter;

  assign b      = chars.char_byte;
  assign num    = (b >= 8'h30) && (b <= 8'h39);
  assign letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));

  assign chars.ready = !full;
  assign push        = chars.valid && !full;

  always_comb begin
    entry.byte_val = b;
    entry.is_zero  = (b == CH_NUL);
    entry.is_num   = num;
    entry.is_other = !num && !letter && (b != CH_SPACE);
    entry.is_lt    = (b == CH_LT);
    entry.is_tab   = (b == CH_TAB);
    entry.is_blank = (b == CH_SPACE) || (b == CH_LF) || (b == CH_TAB);
    entry.is_minus = (b == CH_MINUS);
    entry.is_plus  = (b == CH_PLUS);
    entry.is_dot   = (b == CH_DOT);
  end

endmodule

@@ rtl/arlp_queue.sv @@
module arlp_queue
  import arlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  char_class_t push_entry,
  input  logic        pop,
  output char_class_t head,
  output logic        full,
  output logic        empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  char_class_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

@@ rtl/arlp_back.sv @@
module arlp_back
  import arlp_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
)
(
  input  logic        clk,
  input  logic        rst,
  input  char_class_t head,
  input  logic        empty,
  output logic        pop,
  arlp_out_if.source  results
);

  localparam logic [63:0] LIM64  = mant_limit(MAX_DIGITS);
  localparam int          ACC_W  = bits_for(LIM64);
  localparam int          FRAC_W = $clog2(MAX_DIGITS + 1);
  localparam logic [ACC_W+3:0] LIM_W = (ACC_W + 4)'(LIM64);
  localparam logic [ACC_W-1:0] LIM   = ACC_W'(LIM64);

  phase_t              phase;
  phase_t              phase_next;
  logic [1:0]          tag_cnt;
  logic [1:0]          tag_cnt_next;
  logic [7:0]          held [2];
  logic [7:0]          held_next [2];
  logic [1:0]          held_other;
  logic [1:0]          held_other_next;
  logic [1:0]          held_count;
  logic [1:0]          held_count_next;
  logic                prior_other;
  logic                prior_other_next;
  logic                prior_valid;
  logic                prior_valid_next;
  logic                first_dropped;
  logic                first_dropped_next;
  logic [1:0]          skip_count;
  logic [1:0]          skip_count_next;
  logic [ACC_W-1:0]    acc;
  logic [ACC_W-1:0]    acc_next;
  logic [FRAC_W-1:0]   frac_count;
  logic [FRAC_W-1:0]   frac_count_next;
  logic                negative;
  logic                negative_next;

  logic                emit;
  kind_t               emit_kind;
  logic [7:0]          emit_byte;

  logic [ACC_W+3:0]    prod;
  logic                over;
  logic                tag_hit;
  logic                right_other;
  logic                drop;
  logic [ACC_W+30:0]   mag;
  logic [ACC_W+30:0]   signed_mag;
  logic [FRAC_W+3:0]   frac_ext;

  logic                out_valid;
  kind_t               out_kind;
  logic [7:0]          out_byte;
  logic [30:0]         out_score;
  logic [3:0]          out_frac;
  logic                out_last;

  assign pop = !empty && (!out_valid || results.ready);

  assign prod    = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{ACC_W{1'b0}}, head.byte_val[3:0]};
  assign over    = prod > LIM_W;
  assign tag_hit = (head.byte_val == OPEN_TAG[tag_cnt]);

  assign right_other = (head.is_lt) ? 1'b1 : held_other[1];
  assign drop = (held[0] == CH_SPACE) && prior_valid && prior_other && right_other;

  assign mag        = {31'b0, acc};
  assign signed_mag = negative ? ('0 - mag) : mag;
  assign frac_ext   = {4'b0, frac_count};

  always_comb begin
    phase_next = phase;
    if (pop) begin
      case (phase)
        PH_SEARCH: begin
          if (!head.is_zero && tag_hit && tag_cnt == 2'd2) begin
            phase_next = PH_COLLECT;
          end
        end
        PH_COLLECT: begin
          if (head.is_zero) begin
            phase_next = PH_SEARCH;
          end else if (head.is_lt) begin
            phase_next = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (head.is_zero) begin
            phase_next = PH_SEARCH;
          end else if (skip_count == 2'd2) begin
            phase_next = PH_BLANK;
          end
        end
        PH_BLANK: begin
          if (head.is_zero) begin
            phase_next = PH_SEARCH;
          end else if (head.is_blank) begin
            phase_next = PH_BLANK;
          end else if (head.is_minus || head.is_plus || head.is_num) begin
            phase_next = PH_INT;
          end else if (head.is_dot) begin
            phase_next = PH_FRAC;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_INT, PH_FRAC: begin
          if (head.is_num) begin
            phase_next = phase;
          end else if (phase == PH_INT && head.is_dot) begin
            phase_next = PH_FRAC;
          end else if (head.is_zero) begin
            phase_next = PH_SEARCH;
          end else begin
            phase_next = PH_DONE;
          end
        end
        PH_DONE: begin
          if (head.is_zero) begin
            phase_next = PH_SEARCH;
          end
        end
        default: phase_next = PH_SEARCH;
      endcase
    end
  end

  always_comb begin
    tag_cnt_next       = tag_cnt;
    held_next[0]       = held[0];
    held_next[1]       = held[1];
    held_other_next    = held_other;
    held_count_next    = held_count;
    prior_other_next   = prior_other;
    prior_valid_next   = prior_valid;
    first_dropped_next = first_dropped;
    skip_count_next    = skip_count;
    acc_next           = acc;
    frac_count_next    = frac_count;
    negative_next      = negative;
    emit               = 1'b0;
    emit_kind          = KIND_CMD;
    emit_byte          = held[0];

    if (pop) begin
      case (phase)
        PH_SEARCH: begin
          if (head.is_zero) begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
          end else if (tag_hit) begin
            tag_cnt_next = (tag_cnt == 2'd2) ? 2'd0 : tag_cnt + 2'd1;
          end else begin
            tag_cnt_next = head.is_lt ? 2'd1 : 2'd0;
          end
        end
        PH_COLLECT: begin
          if (head.is_zero) begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
          end else if (head.is_lt) begin
            skip_count_next = 2'd0;
            if (held_count == 2'd2) begin
              prior_other_next = held_other[0];
              prior_valid_next = 1'b1;
              emit             = !drop;
            end
          end else if (head.is_tab) begin
            emit = 1'b0;
          end else if (!first_dropped) begin
            first_dropped_next = 1'b1;
          end else if (held_count != 2'd2) begin
            held_next[held_count[0]]       = head.byte_val;
            held_other_next[held_count[0]] = head.is_other;
            held_count_next                = held_count + 2'd1;
          end else begin
            prior_other_next   = held_other[0];
            prior_valid_next   = 1'b1;
            emit               = !drop;
            held_next[0]       = held[1];
            held_next[1]       = head.byte_val;
            held_other_next[0] = held_other[1];
            held_other_next[1] = head.is_other;
          end
        end
        PH_SKIP: begin
          if (head.is_zero) begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
          end else begin
            skip_count_next = skip_count + 2'd1;
          end
        end
        PH_BLANK: begin
          if (head.is_zero) begin
            emit      = 1'b1;
            emit_kind = KIND_ERROR;
          end else if (head.is_minus) begin
            negative_next = 1'b1;
          end else if (head.is_num) begin
            acc_next = over ? LIM : acc_next;
            if (!over) begin
              acc_next = prod[ACC_W-1:0];
            end
          end else if (!head.is_blank && !head.is_plus && !head.is_dot) begin
            emit      = 1'b1;
            emit_kind = KIND_SCORE;
          end
        end
        PH_INT, PH_FRAC: begin
          if (head.is_num) begin
            if (phase == PH_INT) begin
              acc_next = over ? LIM : prod[ACC_W-1:0];
            end else if (frac_count < FRAC_W'(MAX_DIGITS) && !over) begin
              acc_next        = prod[ACC_W-1:0];
              frac_count_next = frac_count + 1'b1;
            end
          end else if (!(phase == PH_INT && head.is_dot)) begin
            emit      = 1'b1;
            emit_kind = KIND_SCORE;
          end
        end
        default: emit = 1'b0;
      endcase

      if (head.is_zero) begin
        tag_cnt_next       = 2'd0;
        held_count_next    = 2'd0;
        prior_valid_next   = 1'b0;
        first_dropped_next = 1'b0;
        skip_count_next    = 2'd0;
        acc_next           = '0;
        frac_count_next    = '0;
        negative_next      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEARCH;
      tag_cnt       <= 2'd0;
      held_count    <= 2'd0;
      prior_valid   <= 1'b0;
      first_dropped <= 1'b0;
      skip_count    <= 2'd0;
      acc           <= '0;
      frac_count    <= '0;
      negative      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      tag_cnt       <= tag_cnt_next;
      held_count    <= held_count_next;
      prior_valid   <= prior_valid_next;
      first_dropped <= first_dropped_next;
      skip_count    <= skip_count_next;
      acc           <= acc_next;
      frac_count    <= frac_count_next;
      negative      <= negative_next;
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    held[0]     <= held_next[0];
    held[1]     <= held_next[1];
    held_other  <= held_other_next;
    prior_other <= prior_other_next;
    if (pop && emit) begin
      out_kind  <= emit_kind;
      out_byte  <= (emit_kind == KIND_CMD) ? emit_byte : 8'h00;
      out_score <= (emit_kind == KIND_SCORE) ? signed_mag[30:0] : 31'd0;
      out_frac  <= (emit_kind == KIND_SCORE) ? frac_ext[3:0] : 4'd0;
      out_last  <= (emit_kind != KIND_CMD);
    end
  end

  assign results.valid          = out_valid;
  assign results.item_kind      = out_kind;
  assign results.out_byte       = out_byte;
  assign results.score_mantissa = out_score;
  assign results.frac_places    = out_frac;
  assign results.last_of_run    = out_last;

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.is_zero) |=> (phase == PH_SEARCH && acc == '0 && held_count == 2'd0))
    else $error("line end did not clear state");
  a_tag_cnt: assert property (@(posedge clk) disable iff (rst) tag_cnt != 2'd3)
    else $error("tag match count out of range");
  a_acc_limit: assert property (@(posedge clk) disable iff (rst) acc <= LIM)
    else $error("mantissa above limit");
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind != KIND_CMD)))
    else $error("last flag disagrees with item kind");

endmodule

@@ rtl/asr_result_line_parser_top.sv @@
// Speech result line parser.
// chars carries one byte of a result line per beat; a zero byte ends the
// line and returns the parser to its start state. results carries one item
// per beat: a command byte (kind 0), the score as mantissa over ten to
// frac_places (kind 1), or an error when the tag or score is missing
// (kind 2). Score and error items carry last_of_run.
// Throughput is one byte per cycle while results are taken: the front
// classifies each byte into a two-entry queue and the back state machine
// retires one queue entry per cycle into the output register. A byte's result
// is registered as the byte leaves the queue; bytes with no result leave too.
// When the receiver stalls the output register holds its item, the back
// stops, the queue fills and chars.ready drops after at most two more beats.
// Reset (rst, synchronous) empties the queue and output register and puts
// the parser back to searching for the open tag.
module asr_result_line_parser_top
  import arlp_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
)
(
  input  logic       clk,
  input  logic       rst,
  arlp_in_if.sink    chars,
  arlp_out_if.source results
);

  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  char_class_t push_entry;
  char_class_t head;

  arlp_front u_front (
    .chars (chars),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  arlp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (full),
    .empty      (empty)
  );

  arlp_back #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .empty   (empty),
    .pop     (pop),
    .results (results)
  );

endmodule

@@ test/asr_result_line_parser_top_tb.sv @@
module asr_result_line_parser_top_tb
  import arlp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned SCORE_LIMIT = 64'd10 ** MAX_DIGITS_DEFAULT - 64'd1;
  localparam int TARGET_BYTES = 1100;
  localparam int HOLD_AT = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         ch;
    logic signed [30:0] mant;
    logic [3:0]         frac;
    logic               last;
  } result_t;

  logic clk;
  logic rst;

  arlp_in_if  chars_if ();
  arlp_out_if results_if ();

  asr_result_line_parser_top dut (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  logic [7:0]  byte_stream[$];
  result_t     expected_items[$];
  int          total_bytes;
  int          sent_count;
  int          got_count;
  int          fail_count;
  int unsigned send_gap;
  int unsigned send_draw;
  int unsigned recv_wait;
  int unsigned recv_draw;
  int          idle_cycles;

  phase_t          ph;
  int unsigned     tag_cnt;
  logic [7:0]      held[2];
  int unsigned     held_cnt;
  logic [7:0]      prev_byte;
  bit              prev_ok;
  bit              first_gone;
  int unsigned     skip_cnt;
  longint unsigned acc;
  int unsigned     frac_cnt;
  bit              neg;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit digit_byte(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic bit is_other(input logic [7:0] b);
    bit letter;
    letter = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    return !digit_byte(b) && !letter && b != CH_SPACE;
  endfunction

  function automatic result_t make_result(input kind_t k, input logic [7:0] ch,
                                          input logic [30:0] mant, input logic [3:0] frac,
                                          input logic last);
    result_t r;
    r.kind = k;
    r.ch   = ch;
    r.mant = mant;
    r.frac = frac;
    r.last = last;
    return r;
  endfunction

  function automatic result_t score_item();
    longint unsigned m;
    m = neg ? (64'd0 - acc) : acc;
    return make_result(KIND_SCORE, 8'h00, m[30:0], 4'(frac_cnt), 1'b1);
  endfunction

  function automatic bit keep_text_byte(input logic [7:0] x, input bit right_other,
                                        output result_t r);
    bit drop;
    drop = x == CH_SPACE && prev_ok && is_other(prev_byte) && right_other;
    prev_byte = x;
    prev_ok = 1'b1;
    r = make_result(KIND_CMD, x, 31'd0, 4'd0, 1'b0);
    return !drop;
  endfunction

  task automatic clear_line_state();
    ph = PH_SEARCH;
    tag_cnt = 0;
    held[0] = 8'h00;
    held[1] = 8'h00;
    held_cnt = 0;
    prev_byte = 8'h00;
    prev_ok = 1'b0;
    first_gone = 1'b0;
    skip_cnt = 0;
    acc = 0;
    frac_cnt = 0;
    neg = 1'b0;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    result_t         r;
    bit              hit;
    longint unsigned d;
    hit = 1'b0;
    d = longint'(b) - 64'h30;
    r = make_result(KIND_CMD, 8'h00, 31'd0, 4'd0, 1'b0);
    if (b == CH_NUL && ph inside {PH_SEARCH, PH_COLLECT, PH_SKIP, PH_BLANK}) begin
      r = make_result(KIND_ERROR, 8'h00, 31'd0, 4'd0, 1'b1);
      hit = 1'b1;
      clear_line_state();
    end else begin
      case (ph)
        PH_SEARCH: begin
          if (b == OPEN_TAG[tag_cnt]) begin
            tag_cnt++;
          end else begin
            tag_cnt = (b == CH_LT) ? 1 : 0;
          end
          if (tag_cnt >= 3) begin
            tag_cnt = 0;
            ph = PH_COLLECT;
          end
        end
        PH_COLLECT: begin
          if (b == CH_LT) begin
            if (held_cnt >= 2) hit = keep_text_byte(held[0], 1'b1, r);
            ph = PH_SKIP;
            skip_cnt = 0;
          end else if (b != CH_TAB) begin
            if (!first_gone) begin
              first_gone = 1'b1;
            end else if (held_cnt < 2) begin
              held[held_cnt] = b;
              held_cnt++;
            end else begin
              hit = keep_text_byte(held[0], is_other(held[1]), r);
              held[0] = held[1];
              held[1] = b;
            end
          end
        end
        PH_SKIP: begin
          skip_cnt++;
          if (skip_cnt >= 3) ph = PH_BLANK;
        end
        PH_BLANK: begin
          if (!(b inside {CH_SPACE, CH_LF, CH_TAB})) begin
            if (b == CH_MINUS) begin
              neg = 1'b1;
              ph = PH_INT;
            end else if (b == CH_PLUS) begin
              ph = PH_INT;
            end else if (digit_byte(b)) begin
              acc = d;
              ph = PH_INT;
            end else if (b == CH_DOT) begin
              ph = PH_FRAC;
            end else begin
              r = score_item();
              hit = 1'b1;
              ph = PH_DONE;
            end
          end
        end
        PH_INT, PH_FRAC: begin
          if (digit_byte(b)) begin
            if (ph == PH_INT) begin
              if (acc > (SCORE_LIMIT - d) / 10) acc = SCORE_LIMIT;
              else acc = acc * 10 + d;
            end else if (frac_cnt < MAX_DIGITS_DEFAULT && acc <= (SCORE_LIMIT - d) / 10) begin
              acc = acc * 10 + d;
              frac_cnt++;
            end
          end else if (ph == PH_INT && b == CH_DOT) begin
            ph = PH_FRAC;
          end else begin
            r = score_item();
            hit = 1'b1;
            if (b == CH_NUL) clear_line_state();
            else ph = PH_DONE;
          end
        end
        default: begin
          if (b == CH_NUL) clear_line_state();
        end
      endcase
    end
    if (hit) expected_items.push_back(r);
  endtask

  task automatic add_line(input string s);
    for (int i = 0; i < s.len(); i++) byte_stream.push_back(s[i]);
    byte_stream.push_back(CH_NUL);
  endtask

  function automatic logic [7:0] noise_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] text_char();
    string      punct;
    logic [7:0] b;
    punct = "!,.?-;:()*";
    case ($urandom_range(0, 8))
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      2: return 8'h30 + 8'($urandom_range(0, 9));
      3, 4: return CH_SPACE;
      5, 6: return punct[$urandom_range(0, punct.len() - 1)];
      7: return CH_TAB;
      default: begin
        b = noise_byte();
        return (b == CH_LT) ? 8'h7F : b;
      end
    endcase
  endfunction

  task automatic add_random_line();
    logic [7:0]  bytes[$];
    int unsigned shape;
    int unsigned n;
    int unsigned cut;
    shape = $urandom_range(0, 9);
    if (shape == 8) begin
      n = $urandom_range(1, 20);
      repeat (n) bytes.push_back($urandom_range(0, 3) == 0 ? CH_LT : noise_byte());
    end else begin
      n = $urandom_range(0, 2);
      repeat (n) bytes.push_back($urandom_range(0, 1) ? noise_byte() : CH_LT);
      bytes.push_back(8'h3C);
      bytes.push_back(8'h73);
      bytes.push_back(8'h3E);
      n = $urandom_range(0, 9);
      repeat (n) bytes.push_back(text_char());
      bytes.push_back(CH_LT);
      if ($urandom_range(0, 1)) begin
        bytes.push_back(8'h2F);
        bytes.push_back(8'h73);
        bytes.push_back(8'h3E);
      end else begin
        repeat (3) bytes.push_back(noise_byte());
      end
      n = $urandom_range(0, 3);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: bytes.push_back(CH_SPACE);
          1: bytes.push_back(CH_LF);
          default: bytes.push_back(CH_TAB);
        endcase
      end
      case ($urandom_range(0, 3))
        0: bytes.push_back(CH_MINUS);
        1: bytes.push_back(CH_PLUS);
        default: ;
      endcase
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      repeat (n) bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) != 0) begin
        bytes.push_back(CH_DOT);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        repeat (n) bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
      end
      n = $urandom_range(0, 2);
      repeat (n) bytes.push_back(noise_byte());
      if (shape == 9) begin
        cut = $urandom_range(0, bytes.size());
        while (bytes.size() > cut) void'(bytes.pop_back());
      end
    end
    foreach (bytes[i]) byte_stream.push_back(bytes[i]);
    byte_stream.push_back(CH_NUL);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
      send_gap <= 0;
    end else if (chars_if.valid && !chars_if.ready) begin
      // hold the beat
    end else if (chars_if.valid) begin
      parse_byte(chars_if.char_byte);
      sent_count++;
      send_draw = ((sent_count / 128) % 4 == 1) ? 0 : $urandom_range(0, 11);
      if (send_draw == 0 && byte_stream.size() != 0) begin
        chars_if.char_byte <= byte_stream.pop_front();
      end else begin
        chars_if.valid <= 1'b0;
        send_gap <= send_draw;
      end
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
    end else if (byte_stream.size() != 0) begin
      chars_if.valid <= 1'b1;
      chars_if.char_byte <= byte_stream.pop_front();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      recv_wait <= 0;
    end else if (results_if.valid && results_if.ready) begin
      if (expected_items.size() == 0) begin
        $display("%0t: unexpected result expected none actual kind %0d byte %0h", $time,
                 results_if.item_kind, results_if.out_byte);
        fail_count++;
      end else begin
        result_t want;
        want = expected_items.pop_front();
        check_field("item_kind", 32'(want.kind), 32'(results_if.item_kind));
        check_field("out_byte", 32'(want.ch), 32'(results_if.out_byte));
        check_field("score_mantissa", 32'(unsigned'(want.mant)),
                    32'(unsigned'(results_if.score_mantissa)));
        check_field("frac_places", 32'(want.frac), 32'(results_if.frac_places));
        check_field("last_of_run", 32'(want.last), 32'(results_if.last_of_run));
      end
      got_count++;
      if (got_count == HOLD_AT) begin
        results_if.ready <= 1'b0;
        recv_wait <= HOLD_CYCLES;
      end else begin
        recv_draw = ((got_count / 64) % 3 == 2) ? 0 : $urandom_range(0, 11);
        if (recv_draw != 0) begin
          results_if.ready <= 1'b0;
          recv_wait <= recv_draw;
        end
      end
    end else if (!results_if.ready) begin
      if (recv_wait != 0) recv_wait <= recv_wait - 1;
      else results_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.char_byte = 8'h00;
    results_if.ready = 1'b0;
    idle_cycles = 0;
    sent_count = 0;
    got_count = 0;
    fail_count = 0;
    clear_line_state();

    add_line("");
    add_line("x<<s");
    add_line("<s>hello");
    add_line("<s>ab</");
    add_line("<s>\t\377- ,\t x;. y\200</s>\n\t -12.50z9");
    add_line("<s>[ ;. ]</s> +3.14159");
    add_line("<s>abc</s>12345678901.5");
    add_line("<s>abc</s> 1.2345678901");
    add_line("<s>abc</s> 0.0000000001");
    add_line("<s>abc</s> -0");
    add_line("<s>abc</s>\t-.x");
    add_line("<s>abc</s>  ");
    add_line("<s>abc</s> q");
    add_line("\001<s>\001\002\003\004</s> 7");
    total_bytes = TARGET_BYTES;
    while (byte_stream.size() < total_bytes) add_random_line();
    total_bytes = byte_stream.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < total_bytes) @(posedge clk);
    while (expected_items.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ asr_result_line_parser_top.f @@
rtl/arlp_pkg.sv
rtl/arlp_in_if.sv
rtl/arlp_out_if.sv
rtl/arlp_front.sv
rtl/arlp_queue.sv
rtl/arlp_back.sv
rtl/asr_result_line_parser_top.sv
test/asr_result_line_parser_top_tb.sv
